// ===== rtl/core/rhsv_pkg.sv =====
// Shared constants, types and state encodings for the rainbow HSV pixel generator.
package rhsv_pkg;

   localparam int MAX_LEDS    = 64;
   localparam int CNT_W       = 7;
   localparam int IDX_W       = 6;
   localparam int HUE_W       = 16;
   localparam int CH_W        = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_W-1:0] RST_LED_COUNT   = CNT_W'(64);
   localparam logic [HUE_W-1:0] RST_HUE_STEP    = HUE_W'(1024);
   localparam logic [HUE_W-1:0] RST_HUE_ADVANCE = HUE_W'(328);
   localparam logic [CH_W-1:0]  RST_SATURATION  = CH_W'(255);
   localparam logic [CH_W-1:0]  RST_BRIGHTNESS  = CH_W'(255);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LED_COUNT   = 3'd0,
      CSR_HUE_STEP    = 3'd1,
      CSR_HUE_ADVANCE = 3'd2,
      CSR_SATURATION  = 3'd3,
      CSR_BRIGHTNESS  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0] led_count;
      logic [HUE_W-1:0] hue_step;
      logic [HUE_W-1:0] hue_advance;
      logic [CH_W-1:0]  saturation;
      logic [CH_W-1:0]  brightness;
   } cfg_type;

   typedef struct packed {
      logic [HUE_W-1:0] start_hue;
      logic [CNT_W-1:0] led_count;
   } frame_cmd_type;

   typedef struct packed {
      logic          push;
      logic          pop;
      logic          full;
      logic          valid;
   } queue_ctl_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FS,
      BK_FT,
      BK_Q,
      BK_T,
      BK_P,
      BK_WB
   } back_state_type;

endpackage

// ===== rtl/core/rhsv_front.sv =====
// Front end: register file, frame item intake, start hue tracking and frame command issue.
module rhsv_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_frame_tick,
   input  logic                                csr_write,
   input  logic [rhsv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rhsv_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                queue_full,
   output logic                                queue_push,
   output rhsv_pkg::frame_cmd_type             queue_entry,
   output rhsv_pkg::cfg_type                   cfg
);

   rhsv_pkg::cfg_type                   cfg_ff, cfg_in;
   logic [rhsv_pkg::HUE_W-1:0]          start_hue_ff, start_hue_in;
   logic [rhsv_pkg::CNT_W-1:0]          count_sat;
   logic                                accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign cfg       = cfg_ff;

   assign count_sat = (cfg_ff.led_count > rhsv_pkg::CNT_W'(rhsv_pkg::MAX_LEDS)) ?
                      rhsv_pkg::CNT_W'(rhsv_pkg::MAX_LEDS) : cfg_ff.led_count;

   // ticks of zero are dropped; empty frames only advance the start hue
   assign queue_push            = accept && req_frame_tick && (count_sat != '0);
   assign queue_entry.start_hue = start_hue_ff;
   assign queue_entry.led_count = count_sat;

   always_comb begin
      start_hue_in = start_hue_ff;
      if (accept && req_frame_tick) begin
         start_hue_in = start_hue_ff + cfg_ff.hue_advance;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (rhsv_pkg::csr_index_type'(csr_index))
            rhsv_pkg::CSR_LED_COUNT:   cfg_in.led_count   = csr_wdata[rhsv_pkg::CNT_W-1:0];
            rhsv_pkg::CSR_HUE_STEP:    cfg_in.hue_step    = csr_wdata[rhsv_pkg::HUE_W-1:0];
            rhsv_pkg::CSR_HUE_ADVANCE: cfg_in.hue_advance = csr_wdata[rhsv_pkg::HUE_W-1:0];
            rhsv_pkg::CSR_SATURATION:  cfg_in.saturation  = csr_wdata[rhsv_pkg::CH_W-1:0];
            rhsv_pkg::CSR_BRIGHTNESS:  cfg_in.brightness  = csr_wdata[rhsv_pkg::CH_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count   <= rhsv_pkg::RST_LED_COUNT;
         cfg_ff.hue_step    <= rhsv_pkg::RST_HUE_STEP;
         cfg_ff.hue_advance <= rhsv_pkg::RST_HUE_ADVANCE;
         cfg_ff.saturation  <= rhsv_pkg::RST_SATURATION;
         cfg_ff.brightness  <= rhsv_pkg::RST_BRIGHTNESS;
         start_hue_ff       <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         start_hue_ff <= start_hue_in;
      end
   end

endmodule

// ===== rtl/core/rhsv_queue.sv =====
// Small FIFO of frame commands between the front end and the pixel sequencer.
module rhsv_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rhsv_pkg::frame_cmd_type   push_entry,
   input  logic                      pop,
   output rhsv_pkg::frame_cmd_type   head,
   output rhsv_pkg::queue_ctl_type   status
);

   rhsv_pkg::frame_cmd_type           entries_ff [rhsv_pkg::QUEUE_DEPTH];
   logic [rhsv_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rhsv_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rhsv_pkg::QCNT_W-1:0]       fill_ff, fill_in;
   logic                              do_push, do_pop;

   assign status.full  = (fill_ff == rhsv_pkg::QCNT_W'(rhsv_pkg::QUEUE_DEPTH));
   assign status.valid = (fill_ff != '0);
   assign status.push  = do_push;
   assign status.pop   = do_pop;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == rhsv_pkg::QPTR_W'(rhsv_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rhsv_pkg::QPTR_W'(rhsv_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/rhsv_back.sv =====
// Back end: per-pixel HSV to RGB sequencer on one shared multiplier, with the result register.
module rhsv_back (
   input  logic                             clock,
   input  logic                             reset,
   input  rhsv_pkg::cfg_type                cfg,
   input  rhsv_pkg::frame_cmd_type          cmd,
   input  rhsv_pkg::queue_ctl_type          queue_status,
   output logic                             cmd_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rhsv_pkg::IDX_W-1:0]       rsp_led_index,
   output logic [rhsv_pkg::CH_W-1:0]        rsp_red,
   output logic [rhsv_pkg::CH_W-1:0]        rsp_green,
   output logic [rhsv_pkg::CH_W-1:0]        rsp_blue,
   output logic                             rsp_last_pixel
);

   // 255 * 65536, full scale of the q and t numerators
   localparam logic [23:0] DEN = 24'hFF0000;

   function automatic logic [7:0] div255(input logic [15:0] y);
      logic [7:0] est;
      logic [8:0] rem;
      begin
         est = y[15:8];
         rem = {1'b0, y[7:0]} + {1'b0, est};
         div255 = (rem >= 9'd255) ? est + 8'd1 : est;
      end
   endfunction

   rhsv_pkg::back_state_type            state_ff, state_in;
   logic [rhsv_pkg::HUE_W-1:0]          hue_ff, hue_in;
   logic [rhsv_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [rhsv_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [31:0]                         mul_ff, mul_in;
   logic [23:0]                         fs_ff, ts_ff;
   logic [15:0]                         yq_ff, yt_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rhsv_pkg::IDX_W-1:0]          idx_out_ff;
   logic [rhsv_pkg::CH_W-1:0]           red_ff, green_ff, blue_ff;
   logic                                last_out_ff;

   logic [18:0]                         h6;
   logic [2:0]                          sector;
   logic [15:0]                         frac;
   logic [23:0]                         mul_a;
   logic [7:0]                          mul_b;
   logic                                mul_en;
   logic                                start;
   logic                                emit;
   logic                                last;
   logic                                out_free;
   logic [7:0]                          val_p, val_q, val_t, val_v;
   logic [7:0]                          red_in, green_in, blue_in;

   assign h6     = {1'b0, hue_ff, 2'b00} + {2'b00, hue_ff, 1'b0};
   assign sector = h6[18:16];
   assign frac   = h6[15:0];
   assign last   = ({1'b0, idx_ff} + 1'b1) == count_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign val_v = cfg.brightness;
   assign val_p = div255(mul_ff[31:16]);
   assign val_q = div255(yq_ff);
   assign val_t = div255(yt_ff);

   always_comb begin
      unique case (sector)
         3'd0:    begin red_in = val_v; green_in = val_t; blue_in = val_p; end
         3'd1:    begin red_in = val_q; green_in = val_v; blue_in = val_p; end
         3'd2:    begin red_in = val_p; green_in = val_v; blue_in = val_t; end
         3'd3:    begin red_in = val_p; green_in = val_q; blue_in = val_v; end
         3'd4:    begin red_in = val_t; green_in = val_p; blue_in = val_v; end
         default: begin red_in = val_v; green_in = val_p; blue_in = val_q; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rhsv_pkg::BK_IDLE: begin
            if (queue_status.valid) begin
               state_in = rhsv_pkg::BK_FS;
            end
         end
         rhsv_pkg::BK_FS: state_in = rhsv_pkg::BK_FT;
         rhsv_pkg::BK_FT: state_in = rhsv_pkg::BK_Q;
         rhsv_pkg::BK_Q:  state_in = rhsv_pkg::BK_T;
         rhsv_pkg::BK_T:  state_in = rhsv_pkg::BK_P;
         rhsv_pkg::BK_P:  state_in = rhsv_pkg::BK_WB;
         rhsv_pkg::BK_WB: begin
            if (out_free) begin
               state_in = last ? rhsv_pkg::BK_IDLE : rhsv_pkg::BK_FS;
            end
         end
         default: state_in = rhsv_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      start  = 1'b0;
      emit   = 1'b0;
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         rhsv_pkg::BK_IDLE: begin
            mul_en = 1'b0;
            start  = queue_status.valid;
         end
         rhsv_pkg::BK_FS: begin
            mul_a = {8'd0, frac};
            mul_b = cfg.saturation;
         end
         rhsv_pkg::BK_FT: begin
            mul_a = 24'(17'h10000 - {1'b0, frac});
            mul_b = cfg.saturation;
         end
         rhsv_pkg::BK_Q: begin
            mul_a = DEN - fs_ff;
            mul_b = cfg.brightness;
         end
         rhsv_pkg::BK_T: begin
            mul_a = DEN - ts_ff;
            mul_b = cfg.brightness;
         end
         rhsv_pkg::BK_P: begin
            mul_a = {8'(8'd255 - cfg.saturation), 16'd0};
            mul_b = cfg.brightness;
         end
         rhsv_pkg::BK_WB: begin
            mul_en = 1'b0;
            emit   = out_free;
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign cmd_pop = start;
   assign mul_in  = {8'd0, mul_a} * {24'd0, mul_b};

   always_comb begin
      hue_in   = hue_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      if (start) begin
         hue_in   = cmd.start_hue;
         idx_in   = '0;
         count_in = cmd.led_count;
      end else if (emit && !last) begin
         hue_in = hue_ff + cfg.hue_step;
         idx_in = idx_ff + 1'b1;
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhsv_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hue_ff   <= hue_in;
      idx_ff   <= idx_in;
      count_ff <= count_in;
      if (mul_en) begin
         mul_ff <= mul_in;
      end
      if (state_ff == rhsv_pkg::BK_FT) begin
         fs_ff <= mul_ff[23:0];
      end
      if (state_ff == rhsv_pkg::BK_Q) begin
         ts_ff <= mul_ff[23:0];
      end
      if (state_ff == rhsv_pkg::BK_T) begin
         yq_ff <= mul_ff[31:16];
      end
      if (state_ff == rhsv_pkg::BK_P) begin
         yt_ff <= mul_ff[31:16];
      end
      if (emit) begin
         idx_out_ff  <= idx_ff;
         red_ff      <= red_in;
         green_ff    <= green_in;
         blue_ff     <= blue_in;
         last_out_ff <= last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_index  = idx_out_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_ff;
   assign rsp_blue       = blue_ff;
   assign rsp_last_pixel = last_out_ff;

endmodule

// ===== rtl/core/rainbow_hsv_pixel_generator.sv =====
// Top level of the rainbow HSV pixel generator.
// Each accepted frame item with frame_tick set yields led_count result items (capped at 64),
// LED 0 first, with last_pixel on the final one; a count of zero yields none but still moves
// the start hue on. Each pixel runs through the back-end sequencer in five passes through its
// single shared 24x8 multiplier plus one write-back; the next pixel starts only after that
// write-back, which waits while the result side stalls. Up to two frame items wait in a queue
// ahead of the sequencer; the input stalls only when that queue is full.
module rainbow_hsv_pixel_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_frame_tick,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rhsv_pkg::IDX_W-1:0]         rsp_led_index,
   output logic [rhsv_pkg::CH_W-1:0]          rsp_red,
   output logic [rhsv_pkg::CH_W-1:0]          rsp_green,
   output logic [rhsv_pkg::CH_W-1:0]          rsp_blue,
   output logic                               rsp_last_pixel,
   input  logic                               csr_write,
   input  logic [rhsv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rhsv_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rhsv_pkg::cfg_type         cfg;
   rhsv_pkg::frame_cmd_type   push_entry;
   rhsv_pkg::frame_cmd_type   head;
   rhsv_pkg::queue_ctl_type   queue_status;
   logic                      queue_push;
   logic                      cmd_pop;

   rhsv_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_frame_tick (req_frame_tick),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .queue_full     (queue_status.full),
      .queue_push     (queue_push),
      .queue_entry    (push_entry),
      .cfg            (cfg)
   );

   rhsv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .pop        (cmd_pop),
      .head       (head),
      .status     (queue_status)
   );

   rhsv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (head),
      .queue_status   (queue_status),
      .cmd_pop        (cmd_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_index  (rsp_led_index),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

// ===== rtl/core/rhsv_checker.sv =====
// Port-level checker for the rainbow HSV pixel generator, bound to the top level.
module rhsv_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [rhsv_pkg::IDX_W-1:0]         rsp_led_index,
   input  logic [rhsv_pkg::CH_W-1:0]          rsp_red,
   input  logic [rhsv_pkg::CH_W-1:0]          rsp_green,
   input  logic [rhsv_pkg::CH_W-1:0]          rsp_blue,
   input  logic                               rsp_last_pixel
);

   logic [rhsv_pkg::IDX_W-1:0]  exp_idx_ff, exp_idx_in;
   logic                        rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      exp_idx_in = exp_idx_ff;
      if (rsp_take) begin
         exp_idx_in = rsp_last_pixel ? '0 : rsp_led_index + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
      end else begin
         exp_idx_ff <= exp_idx_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_led_index) && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_last_pixel))
      else $error("result item changed while stalled");

   a_idx_order: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_led_index == exp_idx_ff)
      else $error("LED index out of sequence");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

endmodule

bind rainbow_hsv_pixel_generator rhsv_checker u_checker (.*);
